// ===== design/tadvm_pkg.sv =====
package tadvm_pkg;

    localparam int SAMPLE_BITS = 16;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_OPERATING_MODE    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_JERK_LIMIT        = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ABS_LIMIT         = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PACKET_FAIL_LIMIT = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_AXIS_FAIL_LIMIT   = 3'd4;

    localparam logic [7:0] MODE_FULL_A = 8'd11;
    localparam logic [7:0] MODE_LIMITS = 8'd33;
    localparam logic [7:0] MODE_FULL_B = 8'd44;

    localparam logic [7:0]  RST_OPERATING_MODE    = 8'd0;
    localparam logic [15:0] RST_JERK_LIMIT        = 16'd200;
    localparam logic [14:0] RST_ABS_LIMIT         = 15'd2560;
    localparam logic [7:0]  RST_PACKET_FAIL_LIMIT = 8'd20;
    localparam logic [7:0]  RST_AXIS_FAIL_LIMIT   = 8'd10;

    localparam logic [15:0] OVR_AXIS_X   = 16'h0100;
    localparam logic [15:0] OVR_AXIS_Y   = 16'h0400;
    localparam logic [15:0] OVR_AXIS_Z   = 16'h0800;
    localparam logic [15:0] OVR_SEC_MASK = 16'h00E0;

    typedef struct packed {
        logic                          timeout;
        logic                          header_ok;
        logic                          checksum_ok;
        logic                          payload_ok;
        logic                          switched_over;
        logic signed [SAMPLE_BITS-1:0] new_x;
        logic signed [SAMPLE_BITS-1:0] new_y;
        logic signed [SAMPLE_BITS-1:0] new_z;
        logic signed [SAMPLE_BITS-1:0] prev_x;
        logic signed [SAMPLE_BITS-1:0] prev_y;
        logic signed [SAMPLE_BITS-1:0] prev_z;
    } in_word_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_x;
        logic signed [SAMPLE_BITS-1:0] out_y;
        logic signed [SAMPLE_BITS-1:0] out_z;
        logic                          packet_failed;
        logic                          any_fault_seen;
        logic [6:0]                    inter_status;
        logic [15:0]                   latched_status;
        logic [2:0]                    axis_failed;
        logic                          secondary_failed;
    } out_word_t;

endpackage

// ===== design/three_axis_data_validity_monitor_unit.sv =====
// path: input accept to result valid runs through the input register and the result register
// throughput: one word per cycle unless m_ready stalls; set by the single-pass check logic
// the input stage takes a new word while a finished result waits, if the input register is empty
// reset: synchronous active-low aresetn clears valids, counters and latches,
// and loads the default limits and mode
module three_axis_data_validity_monitor_unit #(
    parameter int COUNT_BITS = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  tadvm_pkg::in_word_t                  s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output tadvm_pkg::out_word_t                 m_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tadvm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [tadvm_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import tadvm_pkg::*;

    localparam int EW = ((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16) + 2;
    localparam int LW = (COUNT_BITS > 8) ? COUNT_BITS : 8;
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

    // configuration
    logic [7:0]  mode_reg;
    logic [15:0] jerk_limit_reg;
    logic [14:0] abs_limit_reg;
    logic [7:0]  pkt_limit_reg;
    logic [7:0]  axis_limit_reg;

    // pipeline
    logic      in_valid_reg;
    in_word_t  in_reg;
    logic      out_valid_reg;
    out_word_t out_reg;
    logic      adv;

    // monitor state
    logic [COUNT_BITS-1:0] pkt_cnt_reg, pkt_cnt_next;
    logic [COUNT_BITS-1:0] axis_cnt_reg [3];
    logic [COUNT_BITS-1:0] axis_cnt_next [3];
    logic [15:0] overall_reg, overall_next;
    logic [2:0]  axis_fail_reg, axis_fail_next;
    logic        sec_fail_reg, sec_fail_next;
    logic        fault_reg, fault_next;
    logic        xmark_reg, xmark_next;
    out_word_t   out_next;

    logic full, lim33, bad, pkt_reject, chk;
    logic [COUNT_BITS-1:0] pkt_inc;
    logic signed [SAMPLE_BITS-1:0] new_s  [3];
    logic signed [SAMPLE_BITS-1:0] prev_s [3];
    logic signed [SAMPLE_BITS-1:0] cur_s  [3];
    logic signed [SAMPLE_BITS-1:0] res_s  [3];
    logic signed [EW-1:0] diff [3];
    logic signed [EW-1:0] mag  [3];
    logic signed [EW-1:0] cur_e [3];
    logic signed [EW-1:0] lim_e, jerk_e;
    logic [2:0] out_of, mark, restore, jerk_fail;
    logic [COUNT_BITS-1:0] axis_inc [3];
    logic [15:0] axis_bit [3];

    assign cfg_ready = 1'b1;
    assign adv       = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || adv;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    assign axis_bit[0] = OVR_AXIS_X;
    assign axis_bit[1] = OVR_AXIS_Y;
    assign axis_bit[2] = OVR_AXIS_Z;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= RST_OPERATING_MODE;
            jerk_limit_reg <= RST_JERK_LIMIT;
            abs_limit_reg  <= RST_ABS_LIMIT;
            pkt_limit_reg  <= RST_PACKET_FAIL_LIMIT;
            axis_limit_reg <= RST_AXIS_FAIL_LIMIT;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_OPERATING_MODE:    mode_reg       <= cfg_data[7:0];
                REG_JERK_LIMIT:        jerk_limit_reg <= cfg_data;
                REG_ABS_LIMIT:         abs_limit_reg  <= cfg_data[14:0];
                REG_PACKET_FAIL_LIMIT: pkt_limit_reg  <= cfg_data[7:0];
                REG_AXIS_FAIL_LIMIT:   axis_limit_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (adv) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_data;
        end
        if (adv) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pkt_cnt_reg   <= '0;
            overall_reg   <= '0;
            axis_fail_reg <= '0;
            sec_fail_reg  <= 1'b0;
            fault_reg     <= 1'b0;
            xmark_reg     <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                axis_cnt_reg[i] <= '0;
            end
        end else if (adv) begin
            pkt_cnt_reg   <= pkt_cnt_next;
            overall_reg   <= overall_next;
            axis_fail_reg <= axis_fail_next;
            sec_fail_reg  <= sec_fail_next;
            fault_reg     <= fault_next;
            xmark_reg     <= xmark_next;
            for (int i = 0; i < 3; i++) begin
                axis_cnt_reg[i] <= axis_cnt_next[i];
            end
        end
    end

    assign new_s[0]  = in_reg.new_x;
    assign new_s[1]  = in_reg.new_y;
    assign new_s[2]  = in_reg.new_z;
    assign prev_s[0] = in_reg.prev_x;
    assign prev_s[1] = in_reg.prev_y;
    assign prev_s[2] = in_reg.prev_z;

    assign lim_e  = signed'(EW'(abs_limit_reg));
    assign jerk_e = signed'(EW'(jerk_limit_reg));

    always_comb begin
        full  = (mode_reg == MODE_FULL_A) || (mode_reg == MODE_FULL_B);
        lim33 = (mode_reg == MODE_LIMITS);
        chk   = full || lim33;
        bad   = in_reg.timeout || !in_reg.header_ok || !in_reg.checksum_ok ||
                !in_reg.payload_ok;
        pkt_reject = bad && full;

        overall_next   = overall_reg;
        axis_fail_next = axis_fail_reg;
        sec_fail_next  = sec_fail_reg;
        fault_next     = fault_reg || pkt_reject;

        // packet check
        pkt_inc = (pkt_cnt_reg == CMAX) ? pkt_cnt_reg : pkt_cnt_reg + 1'b1;
        if (pkt_reject) begin
            pkt_cnt_next = pkt_inc;
            if (LW'(pkt_inc) >= LW'(pkt_limit_reg)) begin
                overall_next   = overall_next | OVR_AXIS_X | OVR_AXIS_Y | OVR_AXIS_Z |
                                 OVR_SEC_MASK;
                axis_fail_next = 3'b111;
                sec_fail_next  = 1'b1;
            end
        end else if (LW'(pkt_cnt_reg) < LW'(pkt_limit_reg)) begin
            pkt_cnt_next = '0;
        end else begin
            pkt_cnt_next = pkt_cnt_reg;
        end

        // per-axis checks
        xmark_next = xmark_reg;
        for (int i = 0; i < 3; i++) begin
            cur_s[i] = pkt_reject ? prev_s[i] : new_s[i];
            cur_e[i] = EW'(cur_s[i]);
            diff[i]  = cur_e[i] - EW'(prev_s[i]);
            mag[i]   = diff[i][EW-1] ? -diff[i] : diff[i];
            jerk_fail[i] = mag[i] > jerk_e;
            out_of[i] = (cur_e[i] > lim_e) || (cur_e[i] < -lim_e);
            if (i == 0) begin
                if (out_of[i] && chk) begin
                    xmark_next = in_reg.switched_over ? xmark_reg : 1'b1;
                end else begin
                    xmark_next = 1'b0;
                end
                mark[i] = xmark_next;
            end else begin
                mark[i] = out_of[i] && chk;
            end
            restore[i] = mark[i] && ((!pkt_reject && full) || lim33);

            axis_inc[i] = (axis_cnt_reg[i] == CMAX) ? axis_cnt_reg[i]
                                                    : axis_cnt_reg[i] + 1'b1;
            res_s[i] = cur_s[i];
            if (restore[i]) begin
                fault_next       = 1'b1;
                res_s[i]         = prev_s[i];
                axis_cnt_next[i] = axis_inc[i];
                if (LW'(axis_inc[i]) >= LW'(axis_limit_reg)) begin
                    overall_next      = overall_next | axis_bit[i];
                    axis_fail_next[i] = 1'b1;
                end
            end else if (LW'(axis_cnt_reg[i]) < LW'(axis_limit_reg)) begin
                axis_cnt_next[i] = '0;
            end else begin
                axis_cnt_next[i] = axis_cnt_reg[i];
            end
        end

        out_next.out_x            = res_s[0];
        out_next.out_y            = res_s[1];
        out_next.out_z            = res_s[2];
        out_next.packet_failed    = pkt_reject;
        out_next.any_fault_seen   = fault_next;
        out_next.inter_status     = {jerk_fail, 1'b0, out_of & {3{chk}}};
        out_next.latched_status   = overall_next;
        out_next.axis_failed      = axis_fail_next;
        out_next.secondary_failed = sec_fail_next;
    end

endmodule

// ===== dv/tadvm_result_checker.sv =====
`timescale 1ns / 1ps

module tadvm_result_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  tadvm_pkg::in_word_t                  s_data,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  tadvm_pkg::out_word_t                 m_data,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [tadvm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [tadvm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output int                                   mismatches,
    output int                                   outstanding
);
    import tadvm_pkg::*;

    localparam int CNT_BITS = 8;
    localparam logic [CNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [15:0] AXIS_OVR [3] = '{OVR_AXIS_X, OVR_AXIS_Y, OVR_AXIS_Z};

    logic [7:0]  mode_r;
    logic [15:0] jerk_r;
    logic [14:0] abs_r;
    logic [7:0]  pkt_lim_r;
    logic [7:0]  axis_lim_r;

    logic [CNT_BITS-1:0] pkt_cnt;
    logic [CNT_BITS-1:0] axis_cnt [3];
    logic [15:0]         overall_latch;
    logic [2:0]          axis_latch;
    logic                sec_latch;
    logic                fault_latch;
    logic                x_mark;

    out_word_t screened_q [$];
    out_word_t want_w;

    initial begin
        mismatches = 0;
        outstanding = 0;
    end

    function automatic logic [CNT_BITS-1:0] bump(input logic [CNT_BITS-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    function automatic out_word_t screen_word(input in_word_t w);
        out_word_t r;
        logic full, lim_only, bad, out_of, mark, pfail;
        int cur [3];
        int prv [3];
        int diff, lim, i;
        logic [6:0] flags;
        full = (mode_r == MODE_FULL_A) || (mode_r == MODE_FULL_B);
        lim_only = (mode_r == MODE_LIMITS);
        bad = w.timeout || !w.header_ok || !w.checksum_ok || !w.payload_ok;
        cur[0] = w.new_x;
        cur[1] = w.new_y;
        cur[2] = w.new_z;
        prv[0] = w.prev_x;
        prv[1] = w.prev_y;
        prv[2] = w.prev_z;
        pfail = 1'b0;
        flags = '0;
        lim = int'(abs_r);

        if (bad && full) begin
            cur = prv;
            pkt_cnt = bump(pkt_cnt);
            pfail = 1'b1;
            fault_latch = 1'b1;
            if (pkt_cnt >= pkt_lim_r) begin
                overall_latch |= OVR_AXIS_X | OVR_AXIS_Y | OVR_AXIS_Z | OVR_SEC_MASK;
                axis_latch = 3'b111;
                sec_latch = 1'b1;
            end
        end else if (pkt_cnt < pkt_lim_r) begin
            pkt_cnt = '0;
        end

        for (i = 0; i < 3; i++) begin
            diff = cur[i] - prv[i];
            if (diff < 0) begin
                diff = -diff;
            end
            if (diff > int'(jerk_r)) begin
                flags[i + 4] = 1'b1;
            end
            out_of = (cur[i] > lim) || (cur[i] < -lim);
            if (out_of && (full || lim_only)) begin
                flags[i] = 1'b1;
                if (i == 0) begin
                    if (!w.switched_over) begin
                        x_mark = 1'b1;
                    end
                    mark = x_mark;
                end else begin
                    mark = 1'b1;
                end
            end else begin
                if (i == 0) begin
                    x_mark = 1'b0;
                end
                mark = 1'b0;
            end

            if (mark && ((!pfail && full) || lim_only)) begin
                fault_latch = 1'b1;
                cur[i] = prv[i];
                axis_cnt[i] = bump(axis_cnt[i]);
                if (axis_cnt[i] >= axis_lim_r) begin
                    overall_latch |= AXIS_OVR[i];
                    axis_latch[i] = 1'b1;
                end
            end else if (axis_cnt[i] < axis_lim_r) begin
                axis_cnt[i] = '0;
            end
        end

        r.out_x = SAMPLE_BITS'(cur[0]);
        r.out_y = SAMPLE_BITS'(cur[1]);
        r.out_z = SAMPLE_BITS'(cur[2]);
        r.packet_failed = pfail;
        r.any_fault_seen = fault_latch;
        r.inter_status = flags;
        r.latched_status = overall_latch;
        r.axis_failed = axis_latch;
        r.secondary_failed = sec_latch;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            mode_r = RST_OPERATING_MODE;
            jerk_r = RST_JERK_LIMIT;
            abs_r = RST_ABS_LIMIT;
            pkt_lim_r = RST_PACKET_FAIL_LIMIT;
            axis_lim_r = RST_AXIS_FAIL_LIMIT;
            pkt_cnt = '0;
            axis_cnt = '{default: '0};
            overall_latch = '0;
            axis_latch = '0;
            sec_latch = 1'b0;
            fault_latch = 1'b0;
            x_mark = 1'b0;
            screened_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_OPERATING_MODE:    mode_r = cfg_data[7:0];
                    REG_JERK_LIMIT:        jerk_r = cfg_data;
                    REG_ABS_LIMIT:         abs_r = cfg_data[14:0];
                    REG_PACKET_FAIL_LIMIT: pkt_lim_r = cfg_data[7:0];
                    REG_AXIS_FAIL_LIMIT:   axis_lim_r = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (screened_q.size() == 0) begin
                    $error("result word with nothing expected");
                    mismatches++;
                end else begin
                    want_w = screened_q.pop_front();
                    check_field("out_x", want_w.out_x, m_data.out_x);
                    check_field("out_y", want_w.out_y, m_data.out_y);
                    check_field("out_z", want_w.out_z, m_data.out_z);
                    check_field("packet_failed", want_w.packet_failed, m_data.packet_failed);
                    check_field("any_fault_seen", want_w.any_fault_seen,
                                m_data.any_fault_seen);
                    check_field("inter_status", want_w.inter_status, m_data.inter_status);
                    check_field("latched_status", want_w.latched_status,
                                m_data.latched_status);
                    check_field("axis_failed", want_w.axis_failed, m_data.axis_failed);
                    check_field("secondary_failed", want_w.secondary_failed,
                                m_data.secondary_failed);
                end
            end
            if (s_valid && s_ready) begin
                screened_q.push_back(screen_word(s_data));
            end
        end
        outstanding <= screened_q.size();
    end

endmodule

// ===== dv/tb_three_axis_data_validity_monitor_unit.sv =====
`timescale 1ns / 1ps

module tb_three_axis_data_validity_monitor_unit;
    import tadvm_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    // {timeout, header_ok, checksum_ok, payload_ok}
    localparam logic [3:0] LINK_GOOD      = 4'b0111;
    localparam logic [3:0] LINK_TIMEOUT   = 4'b1111;
    localparam logic [3:0] LINK_NO_HEADER = 4'b0011;
    localparam logic [3:0] LINK_NO_SUM    = 4'b0101;
    localparam logic [3:0] LINK_NO_DATA   = 4'b0110;

    localparam logic [7:0] MODE_OFF      = 8'd0;
    localparam logic [7:0] MODE_ALL_ONES = 8'd255;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_word_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_word_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    int check_errors;
    int check_waiting;

    bit quiet = 1'b0;
    bit hold_off = 1'b0;
    logic [15:0] jerk_now = RST_JERK_LIMIT;
    logic [14:0] abs_now = RST_ABS_LIMIT;

    initial begin
        forever #5 aclk = ~aclk;
    end

    three_axis_data_validity_monitor_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tadvm_result_checker u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (check_errors),
        .outstanding (check_waiting)
    );

    // result side back-pressure
    initial begin
        @(posedge aclk);
        forever begin
            if (hold_off) begin
                hold_off = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge aclk);
            end
        end
    end

    initial begin
        int idle_run;
        idle_run = 0;
        wait (aresetn);
        while (idle_run < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                idle_run = 0;
            end else begin
                idle_run++;
            end
        end
        $display("[three_axis_data_validity_monitor_unit] ERROR");
        $finish;
    end

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic set_config(input logic [7:0] mode, input logic [15:0] jerk,
                              input logic [15:0] abs_word, input logic [7:0] pkt_lim,
                              input logic [7:0] axis_lim);
        write_reg(REG_OPERATING_MODE, {8'($urandom), mode});
        write_reg(REG_JERK_LIMIT, jerk);
        write_reg(REG_ABS_LIMIT, abs_word);
        write_reg(REG_PACKET_FAIL_LIMIT, {8'($urandom), pkt_lim});
        write_reg(REG_AXIS_FAIL_LIMIT, {8'($urandom), axis_lim});
        cfg_valid <= 1'b0;
        jerk_now = jerk;
        abs_now = abs_word[14:0];
    endtask

    task automatic send_word(input in_word_t w);
        if (!quiet && $urandom_range(0, 6) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_packet(input logic [3:0] link, input logic sw,
                               input int nx, input int ny, input int nz,
                               input int px, input int py, input int pz);
        in_word_t w;
        {w.timeout, w.header_ok, w.checksum_ok, w.payload_ok} = link;
        w.switched_over = sw;
        w.new_x = SAMPLE_BITS'(nx);
        w.new_y = SAMPLE_BITS'(ny);
        w.new_z = SAMPLE_BITS'(nz);
        w.prev_x = SAMPLE_BITS'(px);
        w.prev_y = SAMPLE_BITS'(py);
        w.prev_z = SAMPLE_BITS'(pz);
        send_word(w);
    endtask

    // wait for every word in flight to come out, then let the bench idle before returning
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (check_waiting != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] near_limit();
        int lim;
        int v;
        lim = int'(abs_now);
        case ($urandom_range(0, 7))
            0: v = $urandom;
            1: v = lim + $urandom_range(0, 1);
            2: v = -lim - $urandom_range(0, 1);
            default: v = int'($urandom_range(0, 2 * lim + 600)) - lim - 300;
        endcase
        return SAMPLE_BITS'(v);
    endfunction

    function automatic in_word_t random_word(input int bad_pct);
        in_word_t w;
        logic signed [SAMPLE_BITS-1:0] p [3];
        logic signed [SAMPLE_BITS-1:0] n [3];
        int k;
        int span;
        span = int'(jerk_now) + 40;
        for (k = 0; k < 3; k++) begin
            p[k] = near_limit();
            case ($urandom_range(0, 9))
                0: n[k] = near_limit();
                1: n[k] = SAMPLE_BITS'(int'(p[k]) + int'(jerk_now));
                2: n[k] = SAMPLE_BITS'(int'(p[k]) - int'(jerk_now) - 1);
                default: n[k] = SAMPLE_BITS'(int'(p[k]) + int'($urandom_range(0, 2 * span))
                                             - span);
            endcase
        end
        if ($urandom_range(1, 100) > bad_pct) begin
            {w.timeout, w.header_ok, w.checksum_ok, w.payload_ok} = LINK_GOOD;
        end else begin
            {w.timeout, w.header_ok, w.checksum_ok, w.payload_ok} = 4'($urandom);
        end
        w.switched_over = ($urandom_range(0, 2) == 0);
        w.new_x = n[0];
        w.new_y = n[1];
        w.new_z = n[2];
        w.prev_x = p[0];
        w.prev_y = p[1];
        w.prev_z = p[2];
        return w;
    endfunction

    task automatic run_phase(input logic [7:0] mode, input logic [15:0] jerk,
                             input logic [15:0] abs_word, input logic [7:0] pkt_lim,
                             input logic [7:0] axis_lim, input int count,
                             input int bad_pct, input bit squeeze);
        int i;
        set_config(mode, jerk, abs_word, pkt_lim, axis_lim);
        for (i = 0; i < count; i++) begin
            if (squeeze && i == count / 4) begin
                hold_off = 1'b1;
            end
            send_word(random_word(bad_pct));
        end
        drain();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_config(MODE_FULL_A, RST_JERK_LIMIT, 16'(RST_ABS_LIMIT), 8'd255, 8'd255);
        send_packet(LINK_GOOD, 1'b0, 100, 200, -300, 50, 180, -250);
        send_packet(LINK_GOOD, 1'b0, 32767, -32768, 0, 32767, -32768, 0);
        send_packet(LINK_GOOD, 1'b0, 1000, -1000, 2560, 0, 0, 2560);
        send_packet(LINK_GOOD, 1'b0, 2561, -2561, -2560, 2561, -2561, -2560);
        send_packet(LINK_TIMEOUT, 1'b0, 9000, 9000, 9000, 0, 0, 0);
        send_packet(LINK_NO_HEADER, 1'b0, -9000, 9000, 0, 0, 0, 0);
        send_packet(LINK_NO_SUM, 1'b1, 0, -9000, 9000, 0, 0, 0);
        send_packet(LINK_NO_DATA, 1'b0, -9000, -9000, -9000, 100, -100, 3000);
        // switchover holds the x mark: clear, then set, then held, then cleared
        send_packet(LINK_GOOD, 1'b1, 5000, 0, 0, 0, 0, 0);
        send_packet(LINK_GOOD, 1'b0, 5000, 0, 0, 0, 0, 0);
        send_packet(LINK_GOOD, 1'b1, 5000, 0, 0, 0, 0, 0);
        send_packet(LINK_GOOD, 1'b1, 0, 0, 0, 0, 0, 0);
        send_packet(LINK_GOOD, 1'b0, -32768, -32768, -32768, 32767, 32767, 32767);
        drain();

        set_config(MODE_LIMITS, 16'd0, 16'd0, 8'd255, 8'd255);
        send_packet(LINK_TIMEOUT, 1'b0, 1, -1, 0, 0, 0, 0);
        send_packet(LINK_GOOD, 1'b1, 3000, 3000, -3000, 0, 0, 0);
        drain();

        set_config(MODE_OFF, 16'hFFFF, 16'h7FFF, 8'd0, 8'd0);
        send_packet(LINK_NO_DATA, 1'b0, -32768, 32767, 0, 32767, -32768, 0);
        send_packet(LINK_GOOD, 1'b0, -32768, 32767, 1, 0, 0, 0);
        drain();

        run_phase(MODE_FULL_A, RST_JERK_LIMIT, 16'(RST_ABS_LIMIT), 8'd255, 8'd255,
                  150, 25, 1'b0);
        run_phase(MODE_FULL_B, 16'($urandom), 16'($urandom_range(0, 32767)), 8'd200, 8'd200,
                  150, 25, 1'b0);
        run_phase(MODE_LIMITS, 16'd0, 16'd0, 8'd255, 8'd255, 100, 30, 1'b0);
        run_phase(8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom_range(1, 255)),
                  8'($urandom_range(1, 255)), 100, 30, 1'b0);
        run_phase(MODE_FULL_A, 16'hFFFF, 16'h7FFF, 8'd30, 8'd20, 150, 25, 1'b0);
        run_phase(MODE_FULL_B, 16'd300, 16'd1500, 8'd8, 8'd5, 200, 60, 1'b1);
        run_phase(MODE_LIMITS, 16'($urandom), 16'($urandom_range(0, 4000)), 8'd1, 8'd1,
                  150, 30, 1'b0);
        run_phase(MODE_FULL_A, 16'd100, 16'd2000, 8'd0, 8'd0, 130, 30, 1'b0);
        run_phase(MODE_ALL_ONES, 16'($urandom), 16'hFFFF, 8'($urandom), 8'($urandom),
                  50, 30, 1'b0);
        quiet = 1'b1;
        run_phase(MODE_FULL_B, 16'($urandom_range(0, 2000)), 16'($urandom_range(0, 8000)),
                  8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)), 100, 40, 1'b0);

        if (check_errors == 0 && check_waiting == 0) begin
            $display("[three_axis_data_validity_monitor_unit] OK");
        end else begin
            $display("[three_axis_data_validity_monitor_unit] ERROR");
        end
        $finish;
    end

endmodule
